// ----- rtl/firc_pkg.sv -----
// Package for the circular-buffer FIR core: sequencer states and register map constants.
package firc_pkg;

    // Coefficient register file: eight taps, indexed 0..7
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/firc_sample_if.sv -----
// Input stream interface: one signed sample per beat.
interface firc_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/firc_result_if.sv -----
// Output stream interface: filtered sample and clip flag per beat.
interface firc_result_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

// ----- rtl/fir_filter_circular_core.sv -----
// From sample beat to result beat the taps are swept with one multiplier, one tap per cycle.
// A new sample is accepted only when idle, after the last result enters the output register.
// The shared multiplier and accumulator step through the taps one by one under a small sequencer.
// Synchronous active-low reset clears the delay line, write position and control state;
// coefficient 0 resets to the largest positive value and all other coefficients to zero.
module fir_filter_circular_core #(
    parameter int TAPS         = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    firc_sample_if.sink                     i_sample,
    firc_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [firc_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]           i_cfg_data
);
    import firc_pkg::*;

    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int RND_W  = ACC_W + 1;
    localparam int FRAC   = COEF_WIDTH - 1;
    localparam int SH_W   = RND_W - FRAC;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TAPS);

    // State and storage
    t_state                          r_state, n_state;
    logic signed [COEF_WIDTH-1:0]    r_coef [NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0]  r_line [TAPS];
    logic [IDX_W-1:0]                r_wp;
    logic [IDX_W-1:0]                r_idx;
    logic [REG_IDX_W-1:0]            r_tap;
    logic [CNT_W-1:0]                r_cnt;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_filtered;
    logic                            r_clipped;

    logic                            in_beat;
    logic                            out_free;
    logic signed [RND_W-1:0]         rounded;
    logic signed [SH_W-1:0]          shifted;
    logic                            sat_hi;
    logic                            sat_lo;
    logic signed [SAMPLE_WIDTH-1:0]  sat_val;

    assign in_beat  = i_sample.valid && i_sample.ready;
    assign out_free = !r_out_valid || o_result.ready;

    // Round half up, floor shift, saturate
    assign rounded = RND_W'(r_acc) + RND_W'(1 << (FRAC - 1));
    assign shifted = SH_W'(rounded >>> FRAC);
    assign sat_hi  = !shifted[SH_W-1] && (shifted[SH_W-2:SAMPLE_WIDTH-1] != '0);
    assign sat_lo  = shifted[SH_W-1] && (shifted[SH_W-2:SAMPLE_WIDTH-1] != '1);

    always_comb begin
        if (sat_hi) begin
            sat_val = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else if (sat_lo) begin
            sat_val = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            sat_val = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    // Sequencer next state and handshake
    always_comb begin
        n_state        = r_state;
        i_sample.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[0] <= {1'b0, {(COEF_WIDTH-1){1'b1}}};
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Delay line and write position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_line[i] <= '0;
            end
            r_wp <= '0;
        end else if (in_beat) begin
            r_line[r_wp] <= i_sample.sample;
            r_wp         <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
        end
    end

    // Multiply-accumulate: product of tap k registered, added in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_beat) begin
            r_cnt <= '0;
        end else if (r_state == ST_MAC) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_idx <= r_wp;
            r_tap <= '0;
            r_acc <= '0;
        end else if (r_state == ST_MAC) begin
            r_prod <= r_coef[r_tap] * r_line[r_idx];
            r_idx  <= (r_idx == '0) ? LAST_IDX : r_idx - 1'b1;
            r_tap  <= r_tap + 1'b1;
            if (r_cnt != '0) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_filtered <= sat_val;
            r_clipped  <= sat_hi || sat_lo;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.filtered = r_filtered;
    assign o_result.clipped  = r_clipped;

    // Checks
    a_start_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == ST_MAC) && (r_cnt == '0))
        else $error("sample beat did not start the tap sweep");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= LAST_IDX) && (r_state != ST_MAC || r_idx <= LAST_IDX))
        else $error("delay line pointer out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result produced outside the done state");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_cnt <= LAST_CNT))
        else $error("tap counter overran");

endmodule
